[hdl/fcva_pkg.sv]
// ----------------------------------------------------------------------------
// fcva_pkg
// Shared constants, types and tables for the full-circle vector angle unit.
// ----------------------------------------------------------------------------
package fcva_pkg;

	localparam int ITERATIONS      = 16;
	localparam int COMPONENT_WIDTH = 32;

	localparam int IN_W        = 32;
	localparam int ANGLE_W     = 19;
	localparam int TABLE_SIZE  = 24;
	localparam int TBL_W       = 30;
	localparam int GUARD_SHIFT = 28;
	localparam int XY_HEAD     = 3;
	localparam int RND_SHIFT   = 14;

	localparam int CMP_W = (COMPONENT_WIDTH < IN_W) ? COMPONENT_WIDTH : IN_W;
	localparam int XY_W  = XY_HEAD + CMP_W + GUARD_SHIFT;
	localparam int Z_W   = 32;
	localparam int ZC_W  = 31;
	localparam int V_W   = 33;
	localparam int ROT_N = (ITERATIONS < TABLE_SIZE) ? ITERATIONS : TABLE_SIZE;

	localparam logic [V_W-1:0] HALF_PI_Q30       = 33'd1686629713;
	localparam logic [V_W-1:0] PI_Q30            = 33'd3373259426;
	localparam logic [V_W-1:0] THREE_HALF_PI_Q30 = 33'd5059889139;
	localparam logic [V_W-1:0] TWO_PI_Q30        = 33'd6746518852;
	localparam logic [V_W-1:0] RND_HALF          = 33'd8192;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX     = 19'd411774;

	// atan(2^-i) in q0.30, truncated
	localparam logic [TBL_W-1:0] ATAN_Q30 [TABLE_SIZE] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
		30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
		30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
		30'd262143,    30'd131071,    30'd65535,     30'd32767,
		30'd16383,     30'd8191,      30'd4095,      30'd2047,
		30'd1023,      30'd511,       30'd255,       30'd127
	};

	typedef struct packed {
		logic zero;
		logic x_zero;
		logic y_zero;
		logic x_neg;
		logic y_neg;
	} tag_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		tag_t                   tag;
	} rot_t;

endpackage

[hdl/fcva_vec_if.sv]
// ----------------------------------------------------------------------------
// fcva_vec_if
// Input channel: one signed vector per word.
// ----------------------------------------------------------------------------
interface fcva_vec_if;
	import fcva_pkg::*;

	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] x_value;
	logic signed [IN_W-1:0] y_value;

	modport source (output valid, output x_value, output y_value, input ready);
	modport sink (input valid, input x_value, input y_value, output ready);

endinterface

[hdl/fcva_ang_if.sv]
// ----------------------------------------------------------------------------
// fcva_ang_if
// Output channel: polar angle and zero flag per word.
// ----------------------------------------------------------------------------
interface fcva_ang_if;
	import fcva_pkg::*;

	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] angle;
	logic               zero_vector;

	modport source (output valid, output angle, output zero_vector, input ready);
	modport sink (input valid, input angle, input zero_vector, output ready);

endinterface

[hdl/fcva_prep.sv]
// ----------------------------------------------------------------------------
// fcva_prep
// Input stage: component extraction, magnitudes, guard scaling and
// classification of axis and zero cases.
// ----------------------------------------------------------------------------
module fcva_prep (
	input  logic           clk,
	input  logic           arst_n,
	fcva_vec_if.sink       vec,
	output logic           down_valid,
	input  logic           down_ready,
	output fcva_pkg::rot_t down_data
);
	import fcva_pkg::*;

	logic             vld_s1;
	rot_t             rot_s1;
	rot_t             nxt;
	logic [CMP_W-1:0] cx;
	logic [CMP_W-1:0] cy;
	logic [CMP_W-1:0] ax;
	logic [CMP_W-1:0] ay;
	logic             rdy;

	assign cx = vec.x_value[CMP_W-1:0];
	assign cy = vec.y_value[CMP_W-1:0];
	assign ax = cx[CMP_W-1] ? (~cx + 1'b1) : cx;
	assign ay = cy[CMP_W-1] ? (~cy + 1'b1) : cy;

	always_comb begin
		nxt.x          = {{XY_HEAD{1'b0}}, ax, {GUARD_SHIFT{1'b0}}};
		nxt.y          = {{XY_HEAD{1'b0}}, ay, {GUARD_SHIFT{1'b0}}};
		nxt.z          = '0;
		nxt.tag.x_zero = (cx == '0);
		nxt.tag.y_zero = (cy == '0);
		nxt.tag.zero   = (cx == '0) && (cy == '0);
		nxt.tag.x_neg  = cx[CMP_W-1];
		nxt.tag.y_neg  = cy[CMP_W-1];
	end

	assign rdy       = !vld_s1 || down_ready;
	assign vec.ready = rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy) begin
			vld_s1 <= vec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && vec.valid) begin
			rot_s1 <= nxt;
		end
	end

	assign down_valid = vld_s1;
	assign down_data  = rot_s1;

endmodule

[hdl/fcva_rotator.sv]
// ----------------------------------------------------------------------------
// fcva_rotator
// Unrolled cordic vectoring, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module fcva_rotator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  fcva_pkg::rot_t up_data,
	output logic           down_valid,
	input  logic           down_ready,
	output fcva_pkg::rot_t down_data
);
	import fcva_pkg::*;

	logic vld_s [ROT_N];
	rot_t rot_s [ROT_N];
	logic src_v [ROT_N];
	rot_t src_d [ROT_N];
	rot_t nxt   [ROT_N];
	logic rdy   [ROT_N+1];

	assign rdy[ROT_N] = down_ready;

	for (genvar k = 0; k < ROT_N; k++) begin : g_stage
		logic signed [XY_W-1:0] xi;
		logic signed [XY_W-1:0] yi;
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		logic signed [Z_W-1:0]  da;

		if (k == 0) begin : g_first
			assign src_v[k] = up_valid;
			assign src_d[k] = up_data;
		end else begin : g_next
			assign src_v[k] = vld_s[k-1];
			assign src_d[k] = rot_s[k-1];
		end

		assign xi = src_d[k].x;
		assign yi = src_d[k].y;
		assign dx = yi >>> k;
		assign dy = xi >>> k;
		assign da = signed'({{(Z_W-TBL_W){1'b0}}, ATAN_Q30[k]});

		always_comb begin
			nxt[k].tag = src_d[k].tag;
			if (!yi[XY_W-1]) begin
				nxt[k].x = xi + dx;
				nxt[k].y = yi - dy;
				nxt[k].z = src_d[k].z + da;
			end else begin
				nxt[k].x = xi - dx;
				nxt[k].y = yi + dy;
				nxt[k].z = src_d[k].z - da;
			end
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= src_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_v[k]) begin
				rot_s[k] <= nxt[k];
			end
		end
	end

	assign up_ready   = rdy[0];
	assign down_valid = vld_s[ROT_N-1];
	assign down_data  = rot_s[ROT_N-1];

endmodule

[hdl/fcva_fold.sv]
// ----------------------------------------------------------------------------
// fcva_fold
// Clamp, quadrant folding and axis cases, then rounding to q3.16 with
// saturation into the output register.
// ----------------------------------------------------------------------------
module fcva_fold (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  fcva_pkg::rot_t up_data,
	fcva_ang_if.source     res
);
	import fcva_pkg::*;

	logic                   vld_s1;
	logic [V_W-1:0]         ang_s1;
	logic                   zero_s1;
	logic                   vld_s2;
	logic [ANGLE_W-1:0]     ang_s2;
	logic                   zero_s2;
	logic                   rdy1;
	logic                   rdy2;
	logic signed [Z_W-1:0]  zs;
	logic [ZC_W-1:0]        zc;
	logic [V_W-1:0]         zv;
	logic [V_W-1:0]         fold;
	tag_t                   tag;
	logic [V_W-1:0]         rsum;
	logic [ANGLE_W-1:0]     rnd;

	assign zs  = up_data.z;
	assign tag = up_data.tag;

	always_comb begin
		if (zs[Z_W-1]) begin
			zc = '0;
		end else if (zs > signed'({1'b0, HALF_PI_Q30[Z_W-2:0]})) begin
			zc = HALF_PI_Q30[ZC_W-1:0];
		end else begin
			zc = zs[ZC_W-1:0];
		end
	end

	assign zv = {{(V_W-ZC_W){1'b0}}, zc};

	always_comb begin
		if (tag.zero) begin
			fold = '0;
		end else if (tag.x_zero) begin
			fold = tag.y_neg ? THREE_HALF_PI_Q30 : HALF_PI_Q30;
		end else if (tag.y_zero) begin
			fold = tag.x_neg ? PI_Q30 : '0;
		end else if (!tag.x_neg && !tag.y_neg) begin
			fold = zv;
		end else if (tag.x_neg && !tag.y_neg) begin
			fold = PI_Q30 - zv;
		end else if (tag.x_neg) begin
			fold = PI_Q30 + zv;
		end else begin
			fold = TWO_PI_Q30 - zv;
		end
	end

	assign rsum = ang_s1 + RND_HALF;
	assign rnd  = rsum[V_W-1:RND_SHIFT];

	assign rdy2     = !vld_s2 || res.ready;
	assign rdy1     = !vld_s1 || rdy2;
	assign up_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= up_valid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && up_valid) begin
			ang_s1  <= fold;
			zero_s1 <= tag.zero;
		end
		if (rdy2 && vld_s1) begin
			ang_s2  <= (rnd > ANGLE_MAX) ? ANGLE_MAX : rnd;
			zero_s2 <= zero_s1;
		end
	end

	assign res.valid       = vld_s2;
	assign res.angle       = ang_s2;
	assign res.zero_vector = zero_s2;

endmodule

[hdl/full_circle_vector_angle_unit.sv]
// ----------------------------------------------------------------------------
// full_circle_vector_angle_unit
// Polar angle of a signed vector, 0 to below 2pi, unsigned q3.16 radians,
// by cordic vectoring with quadrant folding.
//
//   channel  dir  payload                      handshake
//   vec      in   x_value[31:0], y_value[31:0] valid/ready
//   res      out  angle[18:0], zero_vector     valid/ready
//
// one word per clock sustained while res accepts; the stages are one input
// stage, one stage per cordic micro-rotation, one fold stage and one
// rounding/output stage.
// arst_n clears all valid bits; data registers are not reset.
// each stage moves on when the next one is empty or moving, so a stall on
// res fills bubbles first and only then drops vec.ready.
// ----------------------------------------------------------------------------
module full_circle_vector_angle_unit (
	input logic        clk,
	input logic        arst_n,
	fcva_vec_if.sink   vec,
	fcva_ang_if.source res
);
	import fcva_pkg::*;

	logic a_valid;
	logic a_ready;
	rot_t a_data;
	logic b_valid;
	logic b_ready;
	rot_t b_data;

	fcva_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.vec        (vec),
		.down_valid (a_valid),
		.down_ready (a_ready),
		.down_data  (a_data)
	);

	fcva_rotator u_rot (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (a_valid),
		.up_ready   (a_ready),
		.up_data    (a_data),
		.down_valid (b_valid),
		.down_ready (b_ready),
		.down_data  (b_data)
	);

	fcva_fold u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (b_valid),
		.up_ready (b_ready),
		.up_data  (b_data),
		.res      (res)
	);

endmodule

[hdl/fcva_checker.sv]
// ----------------------------------------------------------------------------
// fcva_checker
// Port-level checks for the vector angle unit, bound to the top level.
// ----------------------------------------------------------------------------
module fcva_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [fcva_pkg::ANGLE_W-1:0] angle,
	input logic                        zero_vector
);
	import fcva_pkg::*;

	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_vector |-> angle == '0)
		else $error("zero vector word with nonzero angle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle <= ANGLE_MAX)
		else $error("angle above full circle");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(zero_vector))
		else $error("stalled output word changed");

	a_in_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input word dropped while stalled");

endmodule

bind full_circle_vector_angle_unit fcva_checker u_fcva_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (vec.valid),
	.in_ready    (vec.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.angle       (res.angle),
	.zero_vector (res.zero_vector)
);

[sim/fcva_angle_checker.sv]
// ----------------------------------------------------------------------------
// fcva_angle_checker
// Watches the vector and angle channels of the full-circle vector angle unit.
// Every accepted vector is run through a bit-exact cordic angle predictor and
// queued; every accepted angle word is compared field by field with the
// oldest queued prediction. Failures and queue depth are handed to the bench.
// ----------------------------------------------------------------------------
module fcva_angle_checker (
	input  logic  clk,
	input  logic  arst_n,
	fcva_vec_if   vec,
	fcva_ang_if   res,
	output int    mismatches,
	output int    pending,
	output int    checked,
	output int    zeros
);
	timeunit 1ns;
	timeprecision 1ps;
	import fcva_pkg::*;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               zero_vector;
	} angle_word_t;

	localparam longint Q30_HALF_PI       = 64'sd1686629713;
	localparam longint Q30_PI            = 64'sd3373259426;
	localparam longint Q30_THREE_HALF_PI = 64'sd5059889139;
	localparam longint Q16_ANGLE_TOP     = 64'sd411774;
	localparam int     ROT_TABLE_LEN     = 24;
	localparam int     Q30_TO_Q16_SHIFT  = 14;
	localparam int     PRESCALE          = 28;

	localparam longint MICRO_ANGLE [ROT_TABLE_LEN] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127
	};

	angle_word_t angle_queue [$];
	int          mismatch_cnt = 0;
	int          checked_cnt  = 0;
	int          zero_cnt     = 0;
	int          pending_cnt  = 0;

	assign mismatches = mismatch_cnt;
	assign pending    = pending_cnt;
	assign checked    = checked_cnt;
	assign zeros      = zero_cnt;

	function automatic longint sign_extend_component(logic [IN_W-1:0] raw);
		longint unsigned mask;
		longint          v;
		mask = (64'd1 << CMP_W) - 64'd1;
		v    = longint'({32'b0, raw} & mask);
		if (v[CMP_W-1])
			v = v - (longint'(1) << CMP_W);
		return v;
	endfunction

	function automatic angle_word_t polar_angle(logic [IN_W-1:0] x_raw, logic [IN_W-1:0] y_raw);
		longint      x;
		longint      y;
		longint      cx;
		longint      cy;
		longint      dx;
		longint      dy;
		longint      z;
		longint      v;
		angle_word_t w;
		x = sign_extend_component(x_raw);
		y = sign_extend_component(y_raw);
		w = '0;
		if (x == 0 && y == 0) begin
			w.zero_vector = 1'b1;
			return w;
		end
		if (x == 0) begin
			v = (y > 0) ? Q30_HALF_PI : Q30_THREE_HALF_PI;
		end else if (y == 0) begin
			v = (x > 0) ? 64'sd0 : Q30_PI;
		end else begin
			cx = (x < 0 ? -x : x) <<< PRESCALE;
			cy = (y < 0 ? -y : y) <<< PRESCALE;
			z  = 0;
			for (int r = 0; r < ITERATIONS && r < ROT_TABLE_LEN; r++) begin
				dx = cy >>> r;
				dy = cx >>> r;
				if (cy >= 0) begin
					cx = cx + dx;
					cy = cy - dy;
					z  = z + MICRO_ANGLE[r];
				end else begin
					cx = cx - dx;
					cy = cy + dy;
					z  = z - MICRO_ANGLE[r];
				end
			end
			if (z < 0)
				z = 0;
			if (z > Q30_HALF_PI)
				z = Q30_HALF_PI;
			if (x > 0 && y > 0)
				v = z;
			else if (x < 0 && y > 0)
				v = Q30_PI - z;
			else if (x < 0)
				v = Q30_PI + z;
			else
				v = 2 * Q30_PI - z;
		end
		if (v < 0)
			v = 0;
		v = (v + (longint'(1) << (Q30_TO_Q16_SHIFT - 1))) >>> Q30_TO_Q16_SHIFT;
		if (v > Q16_ANGLE_TOP)
			v = Q16_ANGLE_TOP;
		w.angle = v[ANGLE_W-1:0];
		return w;
	endfunction

	always @(posedge clk) begin
		angle_word_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				checked_cnt++;
				if (angle_queue.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: unexpected angle word angle=%0d zero_vector=%0b", $time,
						res.angle, res.zero_vector);
				end else begin
					want = angle_queue.pop_front();
					if (want.zero_vector)
						zero_cnt++;
					if (res.angle !== want.angle) begin
						mismatch_cnt++;
						$display("%0t: angle expected %0d actual %0d", $time, want.angle,
							res.angle);
					end
					if (res.zero_vector !== want.zero_vector) begin
						mismatch_cnt++;
						$display("%0t: zero_vector expected %0b actual %0b", $time,
							want.zero_vector, res.zero_vector);
					end
				end
			end
			if (vec.valid && vec.ready)
				angle_queue.push_back(polar_angle(vec.x_value, vec.y_value));
			pending_cnt = angle_queue.size();
		end
	end

endmodule

[sim/tb_full_circle_vector_angle_unit.sv]
// ----------------------------------------------------------------------------
// tb_full_circle_vector_angle_unit
// Drives the full-circle vector angle unit with directed vectors (zero,
// axes, quadrant diagonals, extreme components, angles near 0 and 2pi) and
// then about a thousand random vectors of mixed shape, with random idling on
// both channels and one long output stall. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_full_circle_vector_angle_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import fcva_pkg::*;

	localparam int     RANDOM_WORDS = 950;
	localparam int     IDLE_PCT     = 8;
	localparam int     HOLD_CYCLES  = 200;
	localparam int     DRAIN_CYCLES = 40;
	localparam realtime TIMEOUT     = 1_200_000ns;
	localparam logic signed [IN_W-1:0] S_MAX = 32'sh7fffffff;
	localparam logic signed [IN_W-1:0] S_MIN = 32'sh80000000;

	logic clk;
	logic arst_n;
	bit   quiet;
	bit   hold_req;
	bit   hold_done;
	int   hold_left;
	int   directed_cnt;
	int   random_cnt;
	int   mismatches;
	int   pending;
	int   checked;
	int   zeros;

	fcva_vec_if vec_ch ();
	fcva_ang_if ang_ch ();

	full_circle_vector_angle_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec_ch),
		.res    (ang_ch)
	);

	fcva_angle_checker i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.vec        (vec_ch),
		.res        (ang_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.zeros      (zeros)
	);

	initial clk = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// output side: random back-pressure plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			ang_ch.ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done     = 1'b1;
			hold_left     = HOLD_CYCLES;
			ang_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			ang_ch.ready <= 1'b0;
		end else begin
			ang_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic send_vector(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			vec_ch.valid <= 1'b0;
			@(posedge clk);
		end
		vec_ch.valid   <= 1'b1;
		vec_ch.x_value <= x;
		vec_ch.y_value <= y;
		@(posedge clk);
		while (!vec_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_directed(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y);
		send_vector(x, y);
		directed_cnt++;
	endtask

	function automatic logic signed [IN_W-1:0] edge_component();
		case ($urandom_range(5))
			0: return S_MAX;
			1: return S_MIN;
			2: return 32'sd1;
			3: return -32'sd1;
			4: return 32'sd0;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic signed [IN_W-1:0] tiny_component();
		return IN_W'(int'($urandom_range(128)) - 64);
	endfunction

	initial begin
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		int                     shape;
		arst_n         <= 1'b0;
		vec_ch.valid   <= 1'b0;
		vec_ch.x_value <= '0;
		vec_ch.y_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero vector, axes, quadrant diagonals, extremes
		send_directed(0, 0);
		send_directed(0, 1000);
		send_directed(0, -1000);
		send_directed(1000, 0);
		send_directed(-1000, 0);
		send_directed(0, S_MAX);
		send_directed(0, S_MIN);
		send_directed(S_MAX, 0);
		send_directed(S_MIN, 0);
		send_directed(1, 1);
		send_directed(-1, 1);
		send_directed(-1, -1);
		send_directed(1, -1);
		send_directed(S_MAX, S_MAX);
		send_directed(S_MIN, S_MIN);
		send_directed(S_MIN, S_MAX);
		send_directed(S_MAX, S_MIN);
		send_directed(S_MAX, 1);
		send_directed(1, S_MIN);
		send_directed(S_MIN, -1);
		send_directed(1, S_MAX);
		send_directed(S_MAX, -1);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			quiet = (n >= 300 && n < 500);
			if (n == 350)
				hold_req = 1'b1;
			shape = $urandom_range(99);
			if (shape < 40) begin
				x = $urandom();
				y = $urandom();
			end else if (shape < 55) begin
				x = tiny_component();
				y = tiny_component();
			end else if (shape < 65) begin
				x = $urandom_range(1) ? 32'sd0 : $urandom();
				y = (x == 0) ? $urandom() : 32'sd0;
			end else if (shape < 70) begin
				x = 0;
				y = 0;
			end else if (shape < 80) begin
				x = edge_component();
				y = edge_component();
			end else if (shape < 90) begin
				x = $urandom();
				y = ($urandom_range(1) ? x : -x) + tiny_component();
			end else begin
				x = $urandom();
				y = tiny_component();
				if ($urandom_range(1)) begin
					y = x;
					x = tiny_component();
				end
			end
			send_vector(x, y);
			random_cnt++;
		end
		quiet = 1'b0;
		vec_ch.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d directed and %0d random vectors, %0d angle words checked",
			directed_cnt, random_cnt, checked);
		$display("zero vectors seen: %0d, one output hold-off of %0d cycles", zeros,
			HOLD_CYCLES);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS full_circle_vector_angle_unit");
		end else begin
			$display("FAIL full_circle_vector_angle_unit");
		end
		$finish;
	end

	initial begin
		#TIMEOUT;
		$display("timeout with %0d angle words outstanding", pending);
		$display("FAIL full_circle_vector_angle_unit");
		$finish;
	end

endmodule
